### rtl/ilsa_pkg.sv
`default_nettype none

package ilsa_pkg;

    localparam int NIB_W = 4;
    localparam int REG_W = 16;
    localparam int REG_COUNT = 4;
    localparam logic [3:0] LIMIT_RESET = 4'hf;

    typedef enum logic [1:0] {
        KIND_AUTO    = 2'd0,
        KIND_FIXED   = 2'd1,
        KIND_DISABLE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_LIMIT  = 3'd1,
        ST_BUSY   = 3'd2,
        ST_FULL   = 3'd3,
        ST_BADIDX = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] source;
        logic [3:0] level;
        logic [3:0] slot;
    } req_t;

    typedef struct packed {
        logic [3:0]  granted_slot;
        logic [1:0]  reg_index;
        logic [15:0] reg_value;
        logic [2:0]  status;
    } rsp_t;

endpackage

`default_nettype wire

### rtl/ilsa_if.sv
`default_nettype none

interface ilsa_req_if;
    logic             valid;
    logic             ready;
    ilsa_pkg::req_t   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ilsa_rsp_if;
    logic             valid;
    logic             ready;
    ilsa_pkg::rsp_t   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ilsa_cfg_if;
    logic             valid;
    logic             ready;
    logic [3:0]       data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/ilsa_engine.sv
`default_nettype none

module ilsa_engine #(
    parameter int LEVEL_COUNT = 15
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire ilsa_pkg::req_t req_i,
    input  wire logic           cfg_we,
    input  wire logic [3:0]     cfg_data,
    output ilsa_pkg::rsp_t      rsp_o
);

    localparam int SW = $clog2(LEVEL_COUNT);
    localparam logic [3:0] TOP_POS = 4'(LEVEL_COUNT - 1);
    localparam logic [3:0] LC4 = 4'(LEVEL_COUNT);

    logic [LEVEL_COUNT-1:0] map_reg;
    logic [LEVEL_COUNT-1:0] map_next;
    logic [15:0]            sel_reg [ilsa_pkg::REG_COUNT];
    logic [3:0]             limit_reg;

    logic [LEVEL_COUNT-1:0] free_vec;
    logic [LEVEL_COUNT-1:0] low_onehot;
    logic [SW-1:0]          low_idx;
    logic [3:0]             fixed_slot;
    logic [SW-1:0]          tgt_idx;
    logic [3:0]             nib;
    logic                   set_bit;
    logic                   clr_bit;
    logic                   wr_en;
    logic [3:0]             pos;
    logic [1:0]             ridx;
    logic [15:0]            cur_val;
    logic [15:0]            new_val;
    ilsa_pkg::status_t      st;

    always_comb
    begin
        // lowest free slot: isolate the lowest set bit of the free vector
        free_vec   = ~map_reg;
        low_onehot = free_vec & (LEVEL_COUNT'(0) - free_vec);
        low_idx    = '0;
        for (int i = 0; i < LEVEL_COUNT; i++)
        begin
            if (low_onehot[i])
            begin
                low_idx = low_idx | SW'(i);
            end
        end

        fixed_slot = LC4 - req_i.level;

        tgt_idx = '0;
        nib     = '0;
        set_bit = 1'b0;
        clr_bit = 1'b0;
        st      = ilsa_pkg::ST_OK;

        unique case (ilsa_pkg::kind_t'(req_i.kind))
            ilsa_pkg::KIND_AUTO:
            begin
                if (req_i.source > limit_reg)
                begin
                    st = ilsa_pkg::ST_LIMIT;
                end
                else if (&map_reg)
                begin
                    st = ilsa_pkg::ST_FULL;
                end
                else
                begin
                    tgt_idx = low_idx;
                    nib     = req_i.source;
                    set_bit = 1'b1;
                end
            end
            ilsa_pkg::KIND_FIXED:
            begin
                if ((req_i.level == 4'd0) || (req_i.level > LC4))
                begin
                    st = ilsa_pkg::ST_BADIDX;
                end
                else if (map_reg[fixed_slot[SW-1:0]])
                begin
                    st = ilsa_pkg::ST_BUSY;
                end
                else
                begin
                    tgt_idx = fixed_slot[SW-1:0];
                    nib     = req_i.source;
                    set_bit = 1'b1;
                end
            end
            ilsa_pkg::KIND_DISABLE:
            begin
                if (req_i.slot >= LC4)
                begin
                    st = ilsa_pkg::ST_BADIDX;
                end
                else
                begin
                    tgt_idx = req_i.slot[SW-1:0];
                    clr_bit = 1'b1;
                end
            end
            default:
            begin
                st = ilsa_pkg::ST_BADIDX;
            end
        endcase

        wr_en = set_bit | clr_bit;

        // slot s lives at field position top - s
        pos     = TOP_POS - 4'(tgt_idx);
        ridx    = pos[3:2];
        cur_val = sel_reg[ridx];
        for (int n = 0; n < ilsa_pkg::REG_COUNT; n++)
        begin
            if (pos[1:0] == 2'(n))
            begin
                new_val[n*ilsa_pkg::NIB_W +: ilsa_pkg::NIB_W] = nib;
            end
            else
            begin
                new_val[n*ilsa_pkg::NIB_W +: ilsa_pkg::NIB_W] =
                    cur_val[n*ilsa_pkg::NIB_W +: ilsa_pkg::NIB_W];
            end
        end

        map_next = map_reg;
        if (set_bit)
        begin
            map_next[tgt_idx] = 1'b1;
        end
        if (clr_bit)
        begin
            map_next[tgt_idx] = 1'b0;
        end

        if (wr_en)
        begin
            rsp_o.granted_slot = 4'(tgt_idx);
            rsp_o.reg_index    = ridx;
            rsp_o.reg_value    = new_val;
            rsp_o.status       = ilsa_pkg::ST_OK;
        end
        else
        begin
            rsp_o.granted_slot = '0;
            rsp_o.reg_index    = '0;
            rsp_o.reg_value    = '0;
            rsp_o.status       = st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg   <= '0;
            limit_reg <= ilsa_pkg::LIMIT_RESET;
            for (int r = 0; r < ilsa_pkg::REG_COUNT; r++)
            begin
                sel_reg[r] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
            if (fire && wr_en)
            begin
                map_reg       <= map_next;
                sel_reg[ridx] <= new_val;
            end
        end
    end

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_o.status != ilsa_pkg::ST_OK) |->
            ((rsp_o.granted_slot == 4'd0) && (rsp_o.reg_index == 2'd0)
             && (rsp_o.reg_value == 16'd0)))
        else $error("error result carries nonzero fields");

    a_claim_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && set_bit) |=> map_reg[$past(tgt_idx)])
        else $error("claimed slot not marked taken");

    a_free_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && clr_bit) |=> !map_reg[$past(tgt_idx)])
        else $error("released slot still marked taken");

    a_map_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(fire && wr_en) |=> $stable(map_reg))
        else $error("slot map changed without a transfer");

endmodule

`default_nettype wire

### rtl/interrupt_level_select_allocator_top.sv
// channel  dir  handshake    payload
// req      in   valid/ready  kind, source, level, slot
// rsp      out  valid/ready  granted_slot, reg_index, reg_value, status
// cfg      in   valid/ready  auto_source_limit (4 bits), always ready
//
// one request per cycle sustained while rsp is not stalled; a request passes the
// input register, one pass of the allocate logic and the result register before
// rsp valid rises
// the slot map and selector registers update in the cycle the request leaves
// the input register, so the next request sees them at once
// rsp stalls hold the result register; req keeps being taken while the
// input register is empty or drains into the result register
// asynchronous active-low reset frees all slots, zeroes the selectors and
// sets the source limit to 15
`default_nettype none

module interrupt_level_select_allocator_top #(
    parameter int LEVEL_COUNT = 15
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ilsa_req_if.sink    req,
    ilsa_rsp_if.source  rsp,
    ilsa_cfg_if.sink    cfg
);

    logic            in_valid_reg;
    logic            in_valid_next;
    ilsa_pkg::req_t  in_data_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    ilsa_pkg::rsp_t  out_data_reg;
    ilsa_pkg::rsp_t  eng_rsp;
    logic            advance;
    logic            fire;
    logic            req_xfer;

    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign req_xfer  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (req_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            in_data_reg <= req.data;
        end
        if (fire)
        begin
            out_data_reg <= eng_rsp;
        end
    end

    ilsa_engine #(
        .LEVEL_COUNT (LEVEL_COUNT)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .req_i    (in_data_reg),
        .cfg_we   (cfg.valid && cfg.ready),
        .cfg_data (cfg.data),
        .rsp_o    (eng_rsp)
    );

    a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed request left no result");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("pending request lost while result stalled");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> !$past(fire))
        else $error("request processed into a stalled result register");

endmodule

`default_nettype wire
